[hw/rtl/smue_pkg.sv]
// ----------------------------------------------------------------------------
// smue_pkg
// shared constants, operation codes and transaction types of the update engine
// ----------------------------------------------------------------------------
package smue_pkg;

    // store geometry
    localparam int ENTRY_COUNT = 1024;
    localparam int ADDR_BITS   = $clog2(ENTRY_COUNT);
    localparam int INDEX_BITS  = 10;
    localparam int VALUE_BITS  = 32;
    localparam int COEF_BITS   = 24;
    localparam int FRAC_BITS   = 24;

    // queue depths, powers of two
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 8;

    // operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MOMENTUM = 2'd0;
    localparam logic [1:0] CFG_NESTEROV = 2'd1;
    localparam logic [1:0] CFG_STEP     = 2'd2;

    typedef struct packed {
        logic [1:0]            op;
        logic [INDEX_BITS-1:0] idx;
        logic [VALUE_BITS-1:0] grad;
        logic [VALUE_BITS-1:0] lw;
        logic [VALUE_BITS-1:0] lv;
    } t_cmd;

    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        logic [VALUE_BITS-1:0] weight;
        logic [VALUE_BITS-1:0] velocity;
        logic                  sat;
    } t_result;

    typedef struct packed {
        logic [COEF_BITS-1:0] mu;
        logic                 nesterov;
        logic [COEF_BITS-1:0] step;
    } t_cfg;

endpackage

[hw/rtl/smue_front.sv]
// ----------------------------------------------------------------------------
// smue_front
// accepts input transactions, drops unused codes, queues commands
// ----------------------------------------------------------------------------
module smue_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_op,
    input  logic [smue_pkg::INDEX_BITS-1:0]     i_entry_index,
    input  logic signed [smue_pkg::VALUE_BITS-1:0] i_gradient_value,
    input  logic signed [smue_pkg::VALUE_BITS-1:0] i_load_weight,
    input  logic signed [smue_pkg::VALUE_BITS-1:0] i_load_velocity,
    output logic                                o_cmd_valid,
    output smue_pkg::t_cmd                      o_cmd,
    input  logic                                i_cmd_pop
);

    localparam int PTR_W = $clog2(smue_pkg::CMD_DEPTH);
    localparam int CNT_W = $clog2(smue_pkg::CMD_DEPTH + 1);

    smue_pkg::t_cmd   r_queue [smue_pkg::CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             keep;
    logic             push;
    smue_pkg::t_cmd   cmd_in;

    // op 3 and out-of-range indexes are taken and dropped
    assign keep = (i_op == smue_pkg::OP_LOAD || i_op == smue_pkg::OP_UPDATE ||
                   i_op == smue_pkg::OP_READ) &&
                  (32'(i_entry_index) < smue_pkg::ENTRY_COUNT);

    assign o_in_stall  = (r_count == CNT_W'(smue_pkg::CMD_DEPTH));
    assign push        = i_in_valid && !o_in_stall && keep;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];

    assign cmd_in.op   = i_op;
    assign cmd_in.idx  = i_entry_index;
    assign cmd_in.grad = i_gradient_value;
    assign cmd_in.lw   = i_load_weight;
    assign cmd_in.lv   = i_load_velocity;

    always_comb begin
        n_count = r_count;
        case ({push, i_cmd_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

[hw/rtl/smue_datapath.sv]
// ----------------------------------------------------------------------------
// smue_datapath
// weight and velocity stores, issue interlock and the six-stage update pipe
// ----------------------------------------------------------------------------
module smue_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  smue_pkg::t_cfg       i_cfg,
    input  logic                 i_cmd_valid,
    input  smue_pkg::t_cmd       i_cmd,
    output logic                 o_cmd_pop,
    input  logic                 i_res_pop,
    output logic                 o_res_push,
    output smue_pkg::t_result    o_res
);

    localparam int NSTG  = 6;
    localparam int CRD_W = $clog2(smue_pkg::RES_DEPTH + 1);
    localparam int PRD_W = smue_pkg::VALUE_BITS + smue_pkg::COEF_BITS;

    typedef struct packed {
        logic [31:0] val;
        logic        clip;
    } t_sat;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // rounded product, ties away from zero, negated when neg is set
    function automatic logic [32:0] round_q24(input logic [PRD_W-1:0] p, input logic neg);
        logic [PRD_W-1:0] s;
        logic [32:0]      r;
        s = p + (PRD_W'(1) << (smue_pkg::FRAC_BITS - 1));
        r = {1'b0, s[smue_pkg::FRAC_BITS +: 32]};
        return neg ? (~r + 33'd1) : r;
    endfunction

    function automatic logic [34:0] sx32(input logic [31:0] x);
        return {{3{x[31]}}, x};
    endfunction

    function automatic logic [34:0] sx33(input logic [32:0] x);
        return {{2{x[32]}}, x};
    endfunction

    function automatic t_sat sat32(input logic [34:0] s);
        t_sat res;
        res.clip = 1'b0;
        res.val  = s[31:0];
        if (!s[34] && (|s[33:31])) begin
            res.clip = 1'b1;
            res.val  = 32'h7FFF_FFFF;
        end else if (s[34] && !(&s[33:31])) begin
            res.clip = 1'b1;
            res.val  = 32'h8000_0000;
        end
        return res;
    endfunction

    // stores, undefined until loaded
    logic [smue_pkg::VALUE_BITS-1:0] r_wmem [smue_pkg::ENTRY_COUNT];
    logic [smue_pkg::VALUE_BITS-1:0] r_vmem [smue_pkg::ENTRY_COUNT];

    // per-stage control
    logic                            r_vld [NSTG];
    logic [1:0]                      r_op  [NSTG];
    logic [smue_pkg::INDEX_BITS-1:0] r_idx [NSTG];

    logic [CRD_W-1:0] r_credit;
    logic             hazard;
    logic             issue;

    // stage 1
    logic [31:0] r_g, r_lw, r_lv, r_rd_w, r_rd_v;
    logic [31:0] w1, v1;
    // entry context, stages 2 to 6
    logic [31:0] r_w [1:NSTG-1];
    logic [31:0] r_v [1:NSTG-1];
    // stage 2
    logic [PRD_W-1:0] r_pv, r_pg;
    logic             r_nv, r_ng;
    // stage 3
    logic [32:0] r_mv3, r_sg3;
    // stage 4
    logic [32:0] r_sg4;
    logic [31:0] r_vn4, r_wp4;
    logic        r_clv4, r_clp4;
    // stage 5
    logic [32:0]      r_sg5;
    logic [31:0]      r_vn5, r_wp5, r_wc5;
    logic             r_clv5, r_clp5, r_clc5, r_nn5;
    logic [PRD_W-1:0] r_pn5;
    // stage 6
    logic [32:0] r_sg6, r_mvn6;
    logic [31:0] r_vn6, r_wp6, r_wc6;
    logic        r_clv6, r_clp6, r_clc6;

    t_sat vsum, psum, csum, nsum;
    logic [31:0] wf, vf;
    logic        cf;
    logic        wr;

    // same-index interlock: wait until every earlier write has landed
    always_comb begin
        hazard = 1'b0;
        for (int k = 0; k < NSTG; k++) begin
            if (r_vld[k] && r_op[k] != smue_pkg::OP_READ && r_idx[k] == i_cmd.idx) begin
                hazard = 1'b1;
            end
        end
    end

    assign issue     = i_cmd_valid && !hazard && (r_credit != CRD_W'(smue_pkg::RES_DEPTH));
    assign o_cmd_pop = issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_credit <= r_credit + CRD_W'(issue) - CRD_W'(i_res_pop);
            r_vld[0] <= issue;
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op[0]  <= i_cmd.op;
        r_idx[0] <= i_cmd.idx;
        for (int k = 1; k < NSTG; k++) begin
            r_op[k]  <= r_op[k-1];
            r_idx[k] <= r_idx[k-1];
        end
    end

    // store read and write
    always_ff @(posedge i_clk) begin
        r_rd_w <= r_wmem[i_cmd.idx[smue_pkg::ADDR_BITS-1:0]];
        r_rd_v <= r_vmem[i_cmd.idx[smue_pkg::ADDR_BITS-1:0]];
        if (wr) begin
            r_wmem[r_idx[NSTG-1][smue_pkg::ADDR_BITS-1:0]] <= wf;
            r_vmem[r_idx[NSTG-1][smue_pkg::ADDR_BITS-1:0]] <= vf;
        end
    end

    // a load takes its own values in place of the stored ones
    assign w1 = (r_op[0] == smue_pkg::OP_LOAD) ? r_lw : r_rd_w;
    assign v1 = (r_op[0] == smue_pkg::OP_LOAD) ? r_lv : r_rd_v;

    assign vsum = sat32(sx33(r_mv3) + sx33(r_sg3));
    assign psum = sat32(sx32(r_w[2]) + sx33(r_sg3));
    assign csum = sat32(sx32(r_w[3]) + sx32(r_vn4));
    assign nsum = sat32(sx32(r_w[5]) + sx33(r_mvn6) + sx33(r_sg6));

    always_ff @(posedge i_clk) begin
        // stage 1
        r_g  <= i_cmd.grad;
        r_lw <= i_cmd.lw;
        r_lv <= i_cmd.lv;
        // stage 2: magnitude products
        r_w[1] <= w1;
        r_v[1] <= v1;
        r_pv   <= PRD_W'(mag32(v1)) * PRD_W'(i_cfg.mu);
        r_nv   <= v1[31];
        r_pg   <= PRD_W'(mag32(r_g)) * PRD_W'(i_cfg.step);
        r_ng   <= r_g[31];
        for (int k = 2; k < NSTG; k++) begin
            r_w[k] <= r_w[k-1];
            r_v[k] <= r_v[k-1];
        end
        // stage 3: rounded mu*v and -step*g
        r_mv3 <= round_q24(r_pv, r_nv);
        r_sg3 <= round_q24(r_pg, !r_ng);
        // stage 4: new velocity, plain weight
        r_sg4  <= r_sg3;
        r_vn4  <= vsum.val;
        r_clv4 <= vsum.clip;
        r_wp4  <= psum.val;
        r_clp4 <= psum.clip;
        // stage 5: classical weight, mu*v' product
        r_sg5  <= r_sg4;
        r_vn5  <= r_vn4;
        r_clv5 <= r_clv4;
        r_wp5  <= r_wp4;
        r_clp5 <= r_clp4;
        r_wc5  <= csum.val;
        r_clc5 <= csum.clip;
        r_pn5  <= PRD_W'(mag32(r_vn4)) * PRD_W'(i_cfg.mu);
        r_nn5  <= r_vn4[31];
        // stage 6: rounded mu*v'
        r_sg6  <= r_sg5;
        r_vn6  <= r_vn5;
        r_clv6 <= r_clv5;
        r_wp6  <= r_wp5;
        r_clp6 <= r_clp5;
        r_wc6  <= r_wc5;
        r_clc6 <= r_clc5;
        r_mvn6 <= round_q24(r_pn5, r_nn5);
    end

    // write-back select
    always_comb begin
        wf = r_w[NSTG-1];
        vf = r_v[NSTG-1];
        cf = 1'b0;
        case (r_op[NSTG-1])
            smue_pkg::OP_UPDATE: begin
                if (i_cfg.mu == '0) begin
                    wf = r_wp6;
                    cf = r_clp6;
                end else if (i_cfg.nesterov) begin
                    wf = nsum.val;
                    vf = r_vn6;
                    cf = r_clv6 | nsum.clip;
                end else begin
                    wf = r_wc6;
                    vf = r_vn6;
                    cf = r_clv6 | r_clc6;
                end
            end
            default: begin
                wf = r_w[NSTG-1];
                vf = r_v[NSTG-1];
                cf = 1'b0;
            end
        endcase
    end

    assign wr = r_vld[NSTG-1] && (r_op[NSTG-1] == smue_pkg::OP_LOAD ||
                                  r_op[NSTG-1] == smue_pkg::OP_UPDATE);

    assign o_res_push     = r_vld[NSTG-1];
    assign o_res.idx      = r_idx[NSTG-1];
    assign o_res.weight   = wf;
    assign o_res.velocity = vf;
    assign o_res.sat      = cf;

endmodule

[hw/rtl/smue_resq.sv]
// ----------------------------------------------------------------------------
// smue_resq
// result queue between the update pipe and the output channel
// ----------------------------------------------------------------------------
module smue_resq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  smue_pkg::t_result i_res,
    input  logic              i_pop,
    output logic              o_valid,
    output smue_pkg::t_result o_res
);

    localparam int PTR_W = $clog2(smue_pkg::RES_DEPTH);
    localparam int CNT_W = $clog2(smue_pkg::RES_DEPTH + 1);

    smue_pkg::t_result r_queue [smue_pkg::RES_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_valid = (r_count != '0);
    assign o_res   = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_queue[r_wr_ptr] <= i_res;
        end
    end

endmodule

[hw/rtl/sgd_momentum_update_engine.sv]
// throughput: one transaction per cycle while no entry hazard or output stall holds it
// a load or update to an entry holds back the next transaction on that entry
// until its write-back at the end of the six-stage update pipe
// reset: synchronous active-low; queues, pipe and registers clear, stores keep contents
// ----------------------------------------------------------------------------
// sgd_momentum_update_engine
// sgd step engine with classical or nesterov momentum over q8.24 weight and
// velocity stores; front queue, update pipe and result queue stall apart
// ----------------------------------------------------------------------------
module sgd_momentum_update_engine (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_index,
    input  logic [smue_pkg::COEF_BITS-1:0]         i_cfg_data,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_op,
    input  logic [smue_pkg::INDEX_BITS-1:0]        i_entry_index,
    input  logic signed [smue_pkg::VALUE_BITS-1:0] i_gradient_value,
    input  logic signed [smue_pkg::VALUE_BITS-1:0] i_load_weight,
    input  logic signed [smue_pkg::VALUE_BITS-1:0] i_load_velocity,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [smue_pkg::INDEX_BITS-1:0]        o_result_index,
    output logic signed [smue_pkg::VALUE_BITS-1:0] o_weight_out,
    output logic signed [smue_pkg::VALUE_BITS-1:0] o_velocity_out,
    output logic                                   o_saturated
);

    // configuration registers
    logic [smue_pkg::COEF_BITS-1:0] r_momentum_coef;
    logic                           r_nesterov_mode;
    logic [smue_pkg::COEF_BITS-1:0] r_step_size;
    smue_pkg::t_cfg                 cfg;

    // front to pipe
    logic              cmd_valid;
    smue_pkg::t_cmd    cmd;
    logic              cmd_pop;

    // pipe to result queue
    logic              res_push;
    smue_pkg::t_result res_in;
    smue_pkg::t_result res_out;
    logic              res_pop;

    // the user must let register writes land only while idle, so no shadowing is needed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_momentum_coef <= '0;
            r_nesterov_mode <= 1'b0;
            r_step_size     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                smue_pkg::CFG_MOMENTUM: r_momentum_coef <= i_cfg_data;
                smue_pkg::CFG_NESTEROV: r_nesterov_mode <= i_cfg_data[0];
                smue_pkg::CFG_STEP:     r_step_size     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.mu       = r_momentum_coef;
    assign cfg.nesterov = r_nesterov_mode;
    assign cfg.step     = r_step_size;

    // front: accept, drop unused codes, queue commands
    smue_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_entry_index    (i_entry_index),
        .i_gradient_value (i_gradient_value),
        .i_load_weight    (i_load_weight),
        .i_load_velocity  (i_load_velocity),
        .o_cmd_valid      (cmd_valid),
        .o_cmd            (cmd),
        .i_cmd_pop        (cmd_pop)
    );

    // back: stores and update pipe; issue is credit-limited by the result
    // queue, so the pipe itself never stalls
    smue_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_pop   (res_pop),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue decouples the pipe from output back-pressure
    smue_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .i_pop   (res_pop),
        .o_valid (o_out_valid),
        .o_res   (res_out)
    );

    // a transaction leaves when valid meets no stall
    assign res_pop        = o_out_valid && !i_out_stall;
    assign o_result_index = res_out.idx;
    assign o_weight_out   = res_out.weight;
    assign o_velocity_out = res_out.velocity;
    assign o_saturated    = res_out.sat;

endmodule

[hw/rtl/smue_checker.sv]
// ----------------------------------------------------------------------------
// smue_checker
// port-level checks of the update engine, bound to the top level
// ----------------------------------------------------------------------------
module smue_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic [smue_pkg::INDEX_BITS-1:0]        o_result_index,
    input logic signed [smue_pkg::VALUE_BITS-1:0] o_weight_out,
    input logic signed [smue_pkg::VALUE_BITS-1:0] o_velocity_out,
    input logic                                   o_saturated
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_result_index) &&
            $stable(o_weight_out) && $stable(o_velocity_out) && $stable(o_saturated))
        else $error("stalled result changed");

    // leaving reset, both queues are empty
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("queues not empty after reset");

    // the command queue only fills through an offered transaction
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("input stall without any offered transaction");

endmodule

bind sgd_momentum_update_engine smue_checker u_checker (.*);

[verif/sgd_momentum_update_engine_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_momentum_update_engine_test
// drives load, update, read and unused-code transactions into the update engine under
// several momentum and step settings, mirrors the weight and velocity stores
// in a shadow copy and checks every returned entry field by field
// ----------------------------------------------------------------------------
module sgd_momentum_update_engine_test;

    localparam int         ENTRY_COUNT  = smue_pkg::ENTRY_COUNT;
    localparam int         INDEX_BITS   = smue_pkg::INDEX_BITS;
    localparam int         VALUE_BITS   = smue_pkg::VALUE_BITS;
    localparam int         COEF_BITS    = smue_pkg::COEF_BITS;
    localparam logic [1:0] OP_LOAD      = smue_pkg::OP_LOAD;
    localparam logic [1:0] OP_UPDATE    = smue_pkg::OP_UPDATE;
    localparam logic [1:0] OP_READ      = smue_pkg::OP_READ;
    localparam logic [1:0] CFG_MOMENTUM = smue_pkg::CFG_MOMENTUM;
    localparam logic [1:0] CFG_NESTEROV = smue_pkg::CFG_NESTEROV;
    localparam logic [1:0] CFG_STEP     = smue_pkg::CFG_STEP;

    typedef smue_pkg::t_cmd    t_cmd;
    typedef smue_pkg::t_result t_result;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 16;     // pipe latency plus hazard hold
    localparam int         STUCK_LIMIT   = 2000;   // cycles without any transaction
    localparam int         REPORT_LIMIT  = 10;
    localparam int         PHASE_ITEMS   = 85;
    localparam int         RANDOM_PHASES = 8;

    localparam longint VAL_HI = 64'sd2147483647;
    localparam longint VAL_LO = -VAL_HI - 1;

    localparam logic [VALUE_BITS-1:0] WORD_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] WORD_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] WORD_ONE = 32'h0100_0000;  // 1.0 in q8.24
    localparam logic [COEF_BITS-1:0]  COEF_MAX = '1;
    localparam logic [COEF_BITS-1:0]  COEF_HALF = 24'h80_0000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_we    = 1'b0;
    logic [1:0]             cfg_index = CFG_MOMENTUM;
    logic [COEF_BITS-1:0]   cfg_data  = '0;

    logic                   cmd_valid = 1'b0;
    logic [1:0]             cmd_op    = OP_LOAD;
    logic [INDEX_BITS-1:0]  cmd_index = '0;
    logic [VALUE_BITS-1:0]  cmd_grad  = '0;
    logic [VALUE_BITS-1:0]  cmd_lw    = '0;
    logic [VALUE_BITS-1:0]  cmd_lv    = '0;
    logic                   rx_stall  = 1'b0;

    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [INDEX_BITS-1:0]  o_result_index;
    logic [VALUE_BITS-1:0]  o_weight_out;
    logic [VALUE_BITS-1:0]  o_velocity_out;
    logic                   o_saturated;

    // shadow of the engine state
    logic signed [VALUE_BITS-1:0] shadow_weight   [ENTRY_COUNT];
    logic signed [VALUE_BITS-1:0] shadow_velocity [ENTRY_COUNT];
    logic [COEF_BITS-1:0]         mu_coef     = '0;
    bit                           nesterov_on = 1'b0;
    logic [COEF_BITS-1:0]         step_coef   = '0;

    bit      entry_loaded [ENTRY_COUNT];  // entries written so far by queued loads
    t_cmd    cmd_backlog [$];             // transactions waiting for the driver
    t_result results_due [$];             // entry results still owed by the engine
    t_cmd    cmd_live;
    t_result due_entry;
    t_result oldest_due;

    int  cmds_queued    = 0;
    int  cmds_taken     = 0;
    int  mismatch_count = 0;
    int  stuck_cycles   = 0;
    int  tx_gap         = 0;
    int  rx_hold        = 0;
    bit  quiet_mode     = 1'b0;   // no idling on either side
    bit  stall_next;

    sgd_momentum_update_engine dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (cmd_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (cmd_op),
        .i_entry_index    (cmd_index),
        .i_gradient_value (cmd_grad),
        .i_load_weight    (cmd_lw),
        .i_load_velocity  (cmd_lv),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (rx_stall),
        .o_result_index   (o_result_index),
        .o_weight_out     (o_weight_out),
        .o_velocity_out   (o_velocity_out),
        .o_saturated      (o_saturated)
    );

    always #2 clk = ~clk;

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 55) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // value times unsigned q0.24 coefficient, rounded to nearest, ties away from zero
    function automatic longint scale_round(input longint x,
                                           input logic [COEF_BITS-1:0] m);
        longint unsigned mag;
        longint unsigned prod;
        mag  = (x < 0) ? longint'(-x) : x;
        prod = (mag * m + 64'd8388608) >> 24;
        return (x < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint clamp_value(input longint s, inout bit clipped);
        if (s > VAL_HI) begin
            clipped = 1'b1;
            return VAL_HI;
        end
        if (s < VAL_LO) begin
            clipped = 1'b1;
            return VAL_LO;
        end
        return s;
    endfunction

    // applies one transaction to the shadow stores, gives the entry result it owes
    function automatic bit predict_step(input t_cmd c, output t_result r);
        longint w;
        longint v;
        longint g;
        longint sg;
        bit     clip;
        clip = 1'b0;
        r    = '0;
        if (c.op == OP_UNUSED || int'(c.idx) >= ENTRY_COUNT) return 1'b0;
        w = shadow_weight[c.idx];
        v = shadow_velocity[c.idx];
        case (c.op)
            OP_LOAD: begin
                w = $signed(c.lw);
                v = $signed(c.lv);
            end
            OP_UPDATE: begin
                g  = $signed(c.grad);
                sg = -scale_round(g, step_coef);
                if (mu_coef == '0) begin
                    // plain sgd, velocity untouched
                    w = clamp_value(w + sg, clip);
                end else begin
                    // saturated velocity feeds the weight sum
                    v = clamp_value(scale_round(v, mu_coef) + sg, clip);
                    if (nesterov_on) begin
                        w = clamp_value(w + scale_round(v, mu_coef) + sg, clip);
                    end else begin
                        w = clamp_value(w + v, clip);
                    end
                end
            end
            default: begin
            end
        endcase
        shadow_weight[c.idx]   = w[VALUE_BITS-1:0];
        shadow_velocity[c.idx] = v[VALUE_BITS-1:0];
        r.idx      = c.idx;
        r.weight   = w[VALUE_BITS-1:0];
        r.velocity = v[VALUE_BITS-1:0];
        r.sat      = clip;
        return 1'b1;
    endfunction

    function automatic void queue_cmd(input logic [1:0] op, input int idx,
                                      input logic [VALUE_BITS-1:0] grad,
                                      input logic [VALUE_BITS-1:0] lw,
                                      input logic [VALUE_BITS-1:0] lv);
        t_cmd c;
        c.op   = op;
        c.idx  = INDEX_BITS'(idx);
        c.grad = grad;
        c.lw   = lw;
        c.lv   = lv;
        cmd_backlog = {cmd_backlog, c};
        cmds_queued++;
        if (op == OP_LOAD) entry_loaded[idx] = 1'b1;
    endfunction

    // full-range words, small q8.24 values, and the extremes
    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] x;
        int unsigned           r;
        x = $urandom;
        r = $urandom_range(0, 99);
        if (r < 40) return x;
        if (r < 80) return {{6{x[25]}}, x[25:0]};
        case ($urandom_range(0, 5))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            4:       return WORD_ONE;
            default: return -WORD_ONE;
        endcase
    endfunction

    // every queued transaction taken and every owed result back, then let the pipe settle
    task automatic wait_idle();
        while (cmds_taken != cmds_queued || results_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [COEF_BITS-1:0] mu, input bit nest,
                              input logic [COEF_BITS-1:0] step);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MOMENTUM;
        cfg_data  <= mu;
        @(posedge clk);
        cfg_index <= CFG_NESTEROV;
        cfg_data  <= {{(COEF_BITS-1){1'b0}}, nest};
        @(posedge clk);
        cfg_index <= CFG_STEP;
        cfg_data  <= step;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mu_coef     = mu;
        nesterov_on = nest;
        step_coef   = step;
    endtask

    // driver: one transaction in flight on the input channel, held while stalled
    always @(posedge clk) begin
        if (!rst_n) begin
            cmd_valid <= 1'b0;
        end else begin
            if (cmd_valid && !o_in_stall) begin
                if (predict_step(cmd_live, due_entry)) results_due = {results_due, due_entry};
                cmds_taken++;
            end
            if (!cmd_valid || !o_in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    cmd_valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    cmd_live = cmd_backlog.pop_front();
                    cmd_op    <= cmd_live.op;
                    cmd_index <= cmd_live.idx;
                    cmd_grad  <= cmd_live.grad;
                    cmd_lw    <= cmd_live.lw;
                    cmd_lv    <= cmd_live.lv;
                    cmd_valid <= 1'b1;
                    tx_gap = idle_span();
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transaction against the oldest owed one
    always @(posedge clk) begin
        if (!rst_n) begin
            rx_stall <= 1'b0;
            rx_hold = 0;
        end else begin
            if (o_out_valid && !rx_stall) begin
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: entry %0d w=%h v=%h sat=%b",
                                 o_result_index, o_weight_out, o_velocity_out, o_saturated);
                end else begin
                    oldest_due = results_due.pop_front();
                    if (o_result_index !== oldest_due.idx ||
                        o_weight_out !== oldest_due.weight ||
                        o_velocity_out !== oldest_due.velocity ||
                        o_saturated !== oldest_due.sat) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("mismatch: exp %0d w=%h v=%h s=%b got %0d w=%h v=%h s=%b",
                                     oldest_due.idx, oldest_due.weight, oldest_due.velocity,
                                     oldest_due.sat, o_result_index, o_weight_out,
                                     o_velocity_out, o_saturated);
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
            end else begin
                stall_next = !quiet_mode && ($urandom_range(0, 3) == 0);
                rx_hold = stall_next ? idle_span() + 1 : int'($urandom_range(0, 8));
                rx_stall <= stall_next;
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((cmd_valid && !o_in_stall) || (o_out_valid && !rx_stall)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic [COEF_BITS-1:0] mu;
        logic [COEF_BITS-1:0] step;
        bit                   nest;
        logic [1:0]           op;
        int                   idx;
        int                   hot;
        int                   count;
        int unsigned          r;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain sgd at full step: saturation both ways, zero gradient, ignored op
        set_config('0, 1'b0, COEF_MAX);
        queue_cmd(OP_LOAD, 0, '0, WORD_MAX, WORD_MIN);
        queue_cmd(OP_READ, 0, '1, '1, '1);
        queue_cmd(OP_UPDATE, 0, WORD_MIN, '0, '0);
        queue_cmd(OP_LOAD, 1023, '0, WORD_MIN, WORD_MAX);
        queue_cmd(OP_UPDATE, 1023, WORD_MAX, '0, '0);
        queue_cmd(OP_UNUSED, 5, '1, '1, '1);
        queue_cmd(OP_LOAD, 2, '0, '0, '0);
        queue_cmd(OP_UPDATE, 2, '0, '0, '0);
        queue_cmd(OP_UPDATE, 2, '1, '0, '0);
        queue_cmd(OP_READ, 2, '0, '0, '0);
        wait_idle();

        // classical momentum, half step: rounding ties, back to back on one entry
        set_config(COEF_MAX, 1'b0, COEF_HALF);
        queue_cmd(OP_LOAD, 7, '0, '0, 32'h0000_0001);
        queue_cmd(OP_UPDATE, 7, 32'h0000_0001, '0, '0);
        queue_cmd(OP_UPDATE, 7, '1, '0, '0);
        queue_cmd(OP_UPDATE, 0, WORD_MAX, '0, '0);
        queue_cmd(OP_READ, 7, '0, '0, '0);
        wait_idle();

        // nesterov with half momentum, negative tie on the velocity
        set_config(COEF_HALF, 1'b1, COEF_MAX);
        queue_cmd(OP_LOAD, 3, '0, WORD_ONE, 32'hFFFF_FFFD);
        queue_cmd(OP_UPDATE, 3, 32'h0080_0000, '0, '0);
        queue_cmd(OP_UPDATE, 3, WORD_MIN, '0, '0);
        queue_cmd(OP_UPDATE, 1023, WORD_MAX, '0, '0);
        queue_cmd(OP_READ, 3, '0, '0, '0);
        queue_cmd(OP_UNUSED, 1023, '1, '1, '1);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin mu = '0;       nest = 1'b0; step = COEF_BITS'($urandom); end
                1: begin mu = COEF_MAX; nest = 1'b0; step = COEF_MAX; end
                2: begin mu = COEF_MAX; nest = 1'b1; step = COEF_MAX; end
                3: begin
                    mu   = COEF_BITS'($urandom_range(1, COEF_MAX));
                    nest = 1'b0;
                    step = COEF_BITS'($urandom);
                end
                4: begin
                    mu   = COEF_BITS'($urandom_range(1, COEF_MAX));
                    nest = 1'b1;
                    step = COEF_BITS'($urandom);
                end
                5: begin mu = '0;       nest = 1'b1; step = '0;       end
                6: begin mu = 24'd1;    nest = 1'b1; step = 24'd1;    end
                default: begin
                    mu   = COEF_BITS'($urandom);
                    nest = 1'($urandom_range(0, 1));
                    step = COEF_BITS'($urandom);
                end
            endcase
            set_config(mu, nest, step);
            quiet_mode = (p == 2 || p == RANDOM_PHASES - 1);

            count = 0;
            while (count < PHASE_ITEMS) begin
                // most traffic hits a handful of entries at both ends of the store
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    hot = int'($urandom_range(0, 15));
                    idx = (hot < 8) ? hot : ENTRY_COUNT - 1 - (hot - 8);
                end else begin
                    idx = int'($urandom_range(0, ENTRY_COUNT - 1));
                end
                r = $urandom_range(0, 99);
                if (r < 22)      op = OP_LOAD;
                else if (r < 75) op = OP_UPDATE;
                else if (r < 93) op = OP_READ;
                else             op = OP_UNUSED;
                // an entry is always loaded before it is updated or read
                if ((op == OP_UPDATE || op == OP_READ) && !entry_loaded[idx])
                    op = OP_LOAD;
                queue_cmd(op, idx, random_value(), random_value(), random_value());
                if (op != OP_UNUSED) count++;
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
